// ===== sv/kfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_pkg
// Shared widths and register indexes for the keyed field extractor.
// ----------------------------------------------------------------------------
package kfe_pkg;

  localparam int BYTE_W        = 8;
  localparam int KEY_REG_CHARS = 16;   // key characters held in the two key registers
  localparam int KEY_REG_W     = 64;
  localparam int KEY_LEN_W     = 5;
  localparam int CFG_ADDR_W    = 3;
  localparam int IDX_W         = 6;    // enough for any window index up to 32

  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LOW   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_HIGH  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_KEY_LEN   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OPEN_DLM  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_CLOSE_DLM = 3'd4;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

// ===== sv/kfe_key_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kfe_key_match
// Parallel compare of the byte window against the configured key.
// ----------------------------------------------------------------------------
module kfe_key_match #(
  parameter int KEY_MAX_LEN = 16,
  parameter int LEN_W       = 5
) (
  input  kfe_pkg::byte_t                              win [KEY_MAX_LEN],
  input  logic [kfe_pkg::KEY_REG_CHARS*kfe_pkg::BYTE_W-1:0] key_chars,
  input  logic [LEN_W-1:0]                            eff_len,
  input  logic [LEN_W-1:0]                            seen,
  output logic                                        match
);
  import kfe_pkg::*;

  logic [KEY_MAX_LEN-1:0] pos_ok;

  // window entry j (newest is 0) must equal key character eff_len-1-j
  always_comb begin
    for (int j = 0; j < KEY_MAX_LEN; j++) begin
      logic [IDX_W-1:0] idx;
      byte_t            kc;
      idx = IDX_W'(eff_len) - IDX_W'(j) - IDX_W'(1);
      if (idx < IDX_W'(KEY_REG_CHARS)) begin
        kc = key_chars[idx[3:0]*BYTE_W +: BYTE_W];
      end else begin
        kc = '0;
      end
      if (IDX_W'(j) < IDX_W'(eff_len)) begin
        pos_ok[j] = (win[j] == kc);
      end else begin
        pos_ok[j] = 1'b1;
      end
    end
  end

  assign match = (seen >= eff_len) && (&pos_ok);

endmodule

// ===== sv/keyed_field_extractor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_field_extractor_top
// Finds a configured key in a byte stream and forwards the delimited value.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one text byte per transfer, tlast on the last
//   byte of a buffer. Output stream m_axis carries value bytes; a transfer
//   with tlast high closes the value (tdata 0), and tuser high on it means
//   the buffer ended before the value was closed.
//   Key, key length and delimiters are written over the cfg_* port while
//   no transfer is in flight.
//   Throughput: one byte per cycle while m_axis is not stalled. Each byte is
//   handled in the cycle it is accepted; its result, if any, is in the output
//   register the next cycle. The key compare is a parallel check of a KEY_MAX_LEN byte
//   window against the key, so that compare sets the cycle time.
//   Reset clears the window, byte count and search state and loads register
//   defaults (key length 1, both delimiters 0x27).
//   When m_axis stalls, the pending result holds and s_axis_tready drops;
//   the input is taken again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module keyed_field_extractor_top #(
  parameter int KEY_MAX_LEN = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,   // [7:0] text_byte
  input  logic                               s_axis_tlast,   // last_byte
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,   // [7:0] value_byte
  output logic                               m_axis_tlast,   // value_end
  output logic                               m_axis_tuser,   // [0] not_found
  input  logic                               cfg_we,
  input  logic [kfe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [kfe_pkg::KEY_REG_W-1:0]      cfg_wdata
);
  import kfe_pkg::*;

  localparam int LEN_W = $clog2(KEY_MAX_LEN + 1);

  localparam logic [1:0] PH_KEY   = 2'd0;
  localparam logic [1:0] PH_OPEN  = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // configuration
  logic [KEY_REG_W-1:0] key_low;
  logic [KEY_REG_W-1:0] key_high;
  logic [KEY_LEN_W-1:0] key_length;
  byte_t                open_delim;
  byte_t                close_delim;

  // search state
  byte_t                recent [KEY_MAX_LEN];
  byte_t                recent_next [KEY_MAX_LEN];
  logic [LEN_W-1:0]     bytes_seen;
  logic [LEN_W-1:0]     bytes_seen_next;
  logic [1:0]           phase;
  logic [1:0]           phase_next;

  // output register
  logic                 out_valid;
  byte_t                out_value;
  logic                 out_end;
  logic                 out_nf;

  logic                 acc;
  logic [LEN_W-1:0]     eff_len;
  logic [LEN_W-1:0]     seen_inc;
  logic                 match;
  logic                 res_valid;
  byte_t                res_value;
  logic                 res_end;
  logic                 res_nf;

  assign s_axis_tready = !out_valid || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (key_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (IDX_W'(key_length) > IDX_W'(KEY_MAX_LEN)) begin
      eff_len = LEN_W'(KEY_MAX_LEN);
    end else begin
      eff_len = LEN_W'(key_length);
    end
  end

  always_comb begin
    recent_next[0] = s_axis_tdata;
    for (int i = 1; i < KEY_MAX_LEN; i++) begin
      recent_next[i] = recent[i-1];
    end
    if (bytes_seen < LEN_W'(KEY_MAX_LEN)) begin
      seen_inc = bytes_seen + LEN_W'(1);
    end else begin
      seen_inc = bytes_seen;
    end
  end

  kfe_key_match #(
    .KEY_MAX_LEN (KEY_MAX_LEN),
    .LEN_W       (LEN_W)
  ) u_match (
    .win       (recent_next),
    .key_chars ({key_high, key_low}),
    .eff_len   (eff_len),
    .seen      (seen_inc),
    .match     (match)
  );

  always_comb begin
    phase_next      = phase;
    bytes_seen_next = bytes_seen;
    res_valid       = 1'b0;
    res_value       = s_axis_tdata;
    res_end         = 1'b0;
    res_nf          = 1'b0;
    unique case (phase)
      PH_KEY: begin
        bytes_seen_next = seen_inc;
        if (match) begin
          phase_next = PH_OPEN;
        end
      end
      PH_OPEN: begin
        if (s_axis_tdata == open_delim) begin
          phase_next = PH_VALUE;
        end
      end
      PH_VALUE: begin
        res_valid = 1'b1;
        if (s_axis_tdata == close_delim) begin
          res_value  = '0;
          res_end    = 1'b1;
          phase_next = PH_DONE;
        end
      end
      PH_DONE: begin
      end
      default: begin
      end
    endcase
    if (s_axis_tlast) begin
      if (phase_next != PH_DONE) begin
        res_valid = 1'b1;
        res_value = '0;
        res_end   = 1'b1;
        res_nf    = 1'b1;
      end
      phase_next      = PH_KEY;
      bytes_seen_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low     <= '0;
      key_high    <= '0;
      key_length  <= KEY_LEN_W'(1);
      open_delim  <= 8'd39;
      close_delim <= 8'd39;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_KEY_LOW:   key_low     <= cfg_wdata;
        REG_KEY_HIGH:  key_high    <= cfg_wdata;
        REG_KEY_LEN:   key_length  <= cfg_wdata[KEY_LEN_W-1:0];
        REG_OPEN_DLM:  open_delim  <= cfg_wdata[BYTE_W-1:0];
        REG_CLOSE_DLM: close_delim <= cfg_wdata[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_KEY;
      bytes_seen <= '0;
      for (int i = 0; i < KEY_MAX_LEN; i++) begin
        recent[i] <= '0;
      end
    end else if (acc) begin
      phase      <= phase_next;
      bytes_seen <= bytes_seen_next;
      if (s_axis_tlast) begin
        for (int i = 0; i < KEY_MAX_LEN; i++) begin
          recent[i] <= '0;
        end
      end else if (phase == PH_KEY) begin
        for (int i = 0; i < KEY_MAX_LEN; i++) begin
          recent[i] <= recent_next[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= res_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_value <= res_value;
      out_end   <= res_end;
      out_nf    <= res_nf;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_value;
  assign m_axis_tlast  = out_end;
  assign m_axis_tuser  = out_nf;

`ifndef NO_ASSERTIONS
  a_nf_ends: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("not_found without value_end");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata == '0))
    else $error("end transfer carries nonzero data");

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    (acc && s_axis_tlast) |=> (phase == PH_KEY && bytes_seen == '0))
    else $error("last byte did not rearm the search");

  a_seen_sat: assert property (@(posedge clk) disable iff (rst)
    bytes_seen <= LEN_W'(KEY_MAX_LEN))
    else $error("byte count beyond window size");

  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    (acc && (phase == PH_KEY || phase == PH_OPEN) && !s_axis_tlast) |=> !m_axis_tvalid)
    else $error("result produced while searching");
`endif

endmodule

// ===== tb/keyed_field_extractor_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_field_extractor_top_tb
// Self-checking bench for the keyed field extractor.
// Text buffers are driven in on s_axis, and each byte is run through a local
// copy of the key search and value extraction. Every m_axis transfer is
// compared field by field with the oldest predicted value byte. Directed
// buffers cover the field extremes and the corner cases. Random buffers,
// mostly well-formed key/opener/value/closer runs, go through several key
// settings under three idle mixes; directed buffers add a long receiver
// hold-off and a mid-buffer pause.
// ----------------------------------------------------------------------------
module keyed_field_extractor_top_tb;
  import kfe_pkg::*;

  localparam int KEY_MAX_LEN  = 16;
  localparam int DRAIN_CYCLES = 4;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 5000;
  localparam int REPORT_MAX   = 10;

  typedef enum logic [1:0] {SCAN_KEY, SEEK_OPEN, PASS_VALUE, SCAN_DONE} scan_phase_t;

  typedef struct packed {
    byte_t value;
    logic  fin;
    logic  not_found;
  } value_t;

  typedef struct packed {
    logic [KEY_REG_W-1:0] lo;
    logic [KEY_REG_W-1:0] hi;
    logic [KEY_LEN_W-1:0] len;
    byte_t                open_d;
    byte_t                close_d;
  } cfg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = '0;   // [7:0] text_byte
  logic                  s_axis_tlast = 1'b0; // last_byte
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;        // [7:0] value_byte
  logic                  m_axis_tlast;        // value_end
  logic                  m_axis_tuser;        // [0] not_found
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [KEY_REG_W-1:0]  cfg_wdata = '0;

  keyed_field_extractor_top #(
    .KEY_MAX_LEN(KEY_MAX_LEN)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata)
  );

  // local copy of the registers and of the scan state
  logic [KEY_REG_W-1:0] kchars_lo = '0;
  logic [KEY_REG_W-1:0] kchars_hi = '0;
  logic [KEY_LEN_W-1:0] klen      = 5'd1;
  byte_t                open_dlm  = 8'h27;
  byte_t                close_dlm = 8'h27;
  byte_t                window [KEY_MAX_LEN];
  int                   window_fill = 0;
  scan_phase_t          scan_phase = SCAN_KEY;

  value_t value_q [$];
  int     mismatch_cnt = 0;
  int     sent_cnt = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  logic   hold_on = 1'b0;
  int     stall_cnt = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    foreach (window[i]) window[i] = '0;
  end

  function automatic byte_t key_char(int i);
    logic [2*KEY_REG_W-1:0] k;
    k = {kchars_hi, kchars_lo};
    if (i < KEY_REG_CHARS) begin
      return k[8*i +: 8];
    end
    return '0;
  endfunction

  function automatic int key_len_eff();
    int n;
    n = klen;
    if (n == 0) n = 1;
    if (n > KEY_MAX_LEN) n = KEY_MAX_LEN;
    return n;
  endfunction

  function automatic void extract_step(byte_t c, logic last);
    value_t r;
    bit     have;
    bit     hit;
    int     n;
    have = 1'b0;
    r    = '0;
    case (scan_phase)
      SCAN_KEY: begin
        for (int i = KEY_MAX_LEN - 1; i > 0; i--) window[i] = window[i-1];
        window[0] = c;
        if (window_fill < KEY_MAX_LEN) window_fill++;
        n   = key_len_eff();
        hit = (window_fill >= n);
        for (int i = 0; i < n; i++) begin
          if (window[n-1-i] != key_char(i)) hit = 1'b0;
        end
        if (hit) scan_phase = SEEK_OPEN;
      end
      SEEK_OPEN: begin
        if (c == open_dlm) scan_phase = PASS_VALUE;
      end
      PASS_VALUE: begin
        have = 1'b1;
        if (c == close_dlm) begin
          r = '{8'h00, 1'b1, 1'b0};
          scan_phase = SCAN_DONE;
        end else begin
          r = '{c, 1'b0, 1'b0};
        end
      end
      default: ;
    endcase
    if (last) begin
      // buffer end: a pending value is dropped in favor of the not-found mark
      if (scan_phase != SCAN_DONE) begin
        r    = '{8'h00, 1'b1, 1'b1};
        have = 1'b1;
      end
      foreach (window[i]) window[i] = '0;
      window_fill = 0;
      scan_phase  = SCAN_KEY;
    end
    if (have) value_q.push_back(r);
  endfunction

  always @(posedge clk) begin : monitor_blk
    value_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (value_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_MAX) begin
            $display("%0t ERROR: unexpected transfer value=%02h end=%0b nf=%0b",
                     $realtime, m_axis_tdata, m_axis_tlast, m_axis_tuser);
          end
        end else begin
          want = value_q.pop_front();
          if (m_axis_tdata !== want.value || m_axis_tlast !== want.fin ||
              m_axis_tuser !== want.not_found) begin
            mismatch_cnt++;
            if (mismatch_cnt <= REPORT_MAX) begin
              $display("%0t ERROR: expected value=%02h end=%0b nf=%0b, got %02h %0b %0b",
                       $realtime, want.value, want.fin, want.not_found,
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        extract_step(s_axis_tdata, s_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= !hold_on && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_byte(byte_t b, logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sent_cnt++;
  endtask

  task automatic send_text(byte_t text [$], logic last);
    foreach (text[i]) send_byte(text[i], last && (i == text.size() - 1));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (value_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apply_config(cfg_t c);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_KEY_LOW;
    cfg_wdata <= c.lo;
    @(posedge clk);
    cfg_addr  <= REG_KEY_HIGH;
    cfg_wdata <= c.hi;
    @(posedge clk);
    cfg_addr  <= REG_KEY_LEN;
    cfg_wdata <= KEY_REG_W'(c.len);
    @(posedge clk);
    cfg_addr  <= REG_OPEN_DLM;
    cfg_wdata <= KEY_REG_W'(c.open_d);
    @(posedge clk);
    cfg_addr  <= REG_CLOSE_DLM;
    cfg_wdata <= KEY_REG_W'(c.close_d);
    @(posedge clk);
    cfg_we    <= 1'b0;
    kchars_lo = c.lo;
    kchars_hi = c.hi;
    klen      = c.len;
    open_dlm  = c.open_d;
    close_dlm = c.close_d;
    @(posedge clk);
  endtask

  function automatic cfg_t rand_config();
    cfg_t c;
    bit   narrow;
    narrow = $urandom_range(0, 1);
    for (int i = 0; i < 8; i++) begin
      c.lo[8*i +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(0, 255));
      c.hi[8*i +: 8] = narrow ? 8'(8'h61 + $urandom_range(0, 2)) : 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 9))
      0:       c.len = 5'd0;
      1:       c.len = 5'd16;
      2:       c.len = 5'($urandom_range(17, 31));
      default: c.len = 5'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 4))
      0: begin
        c.open_d  = 8'($urandom_range(0, 255));
        c.close_d = c.open_d;
      end
      1: begin
        c.open_d  = 8'h00;
        c.close_d = 8'hFF;
      end
      default: begin
        c.open_d  = 8'($urandom_range(0, 255));
        c.close_d = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  function automatic byte_t pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return key_char($urandom_range(0, key_len_eff() - 1));
      4:          return open_dlm;
      5:          return close_dlm;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // noise, key (sometimes corrupted), opener, value, closer (sometimes missing); or noise only
  task automatic send_random_buffer();
    byte_t text [$];
    int    form;
    int    n;
    int    k;
    repeat ($urandom_range(0, 4)) text.push_back(pick_byte());
    form = $urandom_range(0, 9);
    if (form != 9) begin
      for (int i = 0; i < key_len_eff(); i++) text.push_back(key_char(i));
      if (form == 7) begin
        k = text.size() - 1 - $urandom_range(0, key_len_eff() - 1);
        text[k] = text[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      repeat ($urandom_range(0, 2)) text.push_back(pick_byte());
      text.push_back(open_dlm);
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      repeat (n) text.push_back(8'($urandom_range(0, 255)));
      if (form != 8) text.push_back(close_dlm);
      repeat ($urandom_range(0, 2)) text.push_back(pick_byte());
    end else begin
      repeat ($urandom_range(1, 10)) text.push_back(pick_byte());
    end
    send_text(text, 1'b1);
  endtask

  task automatic test_reset_defaults();
    // key is one 0x00 byte, both delimiters 0x27
    send_text('{8'h00, 8'h27, 8'h41, 8'hFF, 8'h27, 8'h55}, 1'b1);
    drain_results();
  endtask

  task automatic test_short_window();
    cfg_t c;
    // key {0x00,'x'}: the zeroed window must not match on the first 'x'
    c = '{64'h7800, 64'h0, 5'd2, 8'h3D, 8'h3B};
    apply_config(c);
    send_text('{8'h78, 8'h3D, 8'h76, 8'h3B, 8'h00}, 1'b1);
    send_text('{8'h00, 8'h78, 8'h3D, 8'h76, 8'h3B, 8'h71}, 1'b1);
    drain_results();
  endtask

  task automatic test_key_length_zero();
    cfg_t c;
    c = '{64'h6B, 64'h0, 5'd0, 8'hFF, 8'h00};
    apply_config(c);
    send_text('{8'h6B, 8'hFF, 8'h00}, 1'b1);   // closer on final byte
    send_text('{8'h6B, 8'hFF, 8'h7A}, 1'b1);   // value cut by buffer end
    drain_results();
  endtask

  task automatic test_backpressure();
    cfg_t  c;
    byte_t text [$];
    byte_t b;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    c = '{64'h6B, 64'h0, 5'd1, 8'h3D, 8'h3B};
    apply_config(c);
    text = '{8'h20, 8'h6B, 8'h3D};
    repeat (32) begin
      b = 8'($urandom_range(0, 255));
      if (b == 8'h3B) b = 8'h21;
      text.push_back(b);
    end
    text.push_back(8'h3B);
    text.push_back(8'h65);
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    send_text(text, 1'b1);
    drain_results();
  endtask

  task automatic test_pause_mid_buffer();
    cfg_t c;
    send_idle_pct = 23;
    recv_idle_pct = 57;
    c = '{64'h6B, 64'h0, 5'd1, 8'h3D, 8'h3B};
    apply_config(c);
    send_text('{8'h6B, 8'h3D, 8'h61, 8'h62}, 1'b0);
    drain_results();
    c.close_d = 8'h23;
    apply_config(c);
    send_text('{8'h3B, 8'h63, 8'h23, 8'h78}, 1'b1);
    drain_results();
  endtask

  task automatic test_random_traffic(int s_pct, int r_pct, int items, cfg_t first);
    int target;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    target = sent_cnt + items;
    apply_config(first);
    while (sent_cnt < target) begin
      if ($urandom_range(0, 5) == 0) begin
        drain_results();
        apply_config(rand_config());
      end
      send_random_buffer();
    end
    drain_results();
  endtask

  initial begin
    cfg_t ext_a;
    cfg_t ext_b;
    ext_a = '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16, 8'h00, 8'hFF};
    ext_b = '{64'h0, 64'h0, 5'd31, 8'hFF, 8'h00};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_short_window();
    test_key_length_zero();
    test_backpressure();
    test_pause_mid_buffer();
    test_random_traffic(23, 57, 200, ext_a);
    test_random_traffic(57, 23, 200, ext_b);
    test_random_traffic(0, 0, 200, rand_config());
    mismatch_cnt += value_q.size();
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
